@@ sv/ppem_pkg.sv @@
package ppem_pkg;

    localparam int VALUE_W        = 31;
    localparam int MASK_W         = 32;
    localparam int EXP_W          = 6;
    localparam int ROOT_W         = 16;
    localparam int SLOT_W         = 5;
    localparam int PROD_W         = VALUE_W + ROOT_W;

    localparam logic [EXP_W-1:0] MIN_EXPONENT   = 6'd2;
    localparam logic [EXP_W-1:0] TOP_EXPONENT   = 6'd33;
    localparam logic [EXP_W-1:0] MAX_EXP_RESET  = 6'd33;
    localparam logic [VALUE_W-1:0] SQRT_BIT_INIT = 31'h4000_0000;

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic search_init;
        logic probe_init;
        logic mul_step;
        logic compare;
        logic exp_next;
    } ppem_cmd_t;

    typedef struct packed {
        logic sqrt_busy;
        logic exp_none;
        logic search_over;
        logic power_done;
        logic match;
        logic exp_last;
    } ppem_status_t;

endpackage

@@ sv/ppem_datapath.sv @@
module ppem_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppem_pkg::EXP_W-1:0]     cfg_wdata,
    input  logic [ppem_pkg::VALUE_W-1:0]   value,
    input  ppem_pkg::ppem_cmd_t            cmd,
    output ppem_pkg::ppem_status_t         status,
    output logic [ppem_pkg::MASK_W-1:0]    exponent_mask
);
    import ppem_pkg::*;

    logic [EXP_W-1:0]   max_exponent_reg;
    logic [VALUE_W-1:0] n_reg;
    logic [VALUE_W-1:0] v_reg;
    logic [VALUE_W-1:0] root_reg;
    logic [VALUE_W-1:0] bit_reg;
    logic [EXP_W-1:0]   k_reg;
    logic [EXP_W-1:0]   top_reg;
    logic [EXP_W-1:0]   cnt_reg;
    logic [ROOT_W-1:0]  lo_reg;
    logic [ROOT_W-1:0]  hi_reg;
    logic [ROOT_W-1:0]  mid_reg;
    logic [VALUE_W-1:0] p_reg;
    logic               ovf_reg;
    logic [MASK_W-1:0]  mask_reg;

    logic [VALUE_W:0]   sqrt_sum;
    logic [ROOT_W:0]    mid_sum;
    logic [ROOT_W-1:0]  mid_next;
    logic [PROD_W-1:0]  product;
    logic [EXP_W-1:0]   top_next;
    logic [SLOT_W-1:0]  slot;

    assign sqrt_sum = {1'b0, root_reg} + {1'b0, bit_reg};
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next = mid_sum[ROOT_W:1];
    assign product  = PROD_W'(p_reg) * PROD_W'(mid_reg);
    assign top_next = (max_exponent_reg > TOP_EXPONENT) ? TOP_EXPONENT : max_exponent_reg;
    assign slot     = SLOT_W'(k_reg - MIN_EXPONENT);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_exponent_reg <= MAX_EXP_RESET;
        end
        else if (cfg_we) begin
            max_exponent_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            n_reg    <= value;
            v_reg    <= value;
            root_reg <= '0;
            bit_reg  <= SQRT_BIT_INIT;
            mask_reg <= '0;
            k_reg    <= MIN_EXPONENT;
            top_reg  <= top_next;
        end
        if (cmd.sqrt_step) begin
            if ({1'b0, v_reg} >= sqrt_sum) begin
                v_reg    <= v_reg - sqrt_sum[VALUE_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.exp_next) begin
            k_reg <= k_reg + 6'd1;
        end
        if (cmd.search_init) begin
            lo_reg <= 16'd1;
            hi_reg <= root_reg[ROOT_W-1:0] + 16'd1;
        end
        if (cmd.probe_init) begin
            mid_reg <= mid_next;
            p_reg   <= VALUE_W'(mid_next);
            ovf_reg <= 1'b0;
            cnt_reg <= 6'd1;
        end
        if (cmd.mul_step) begin
            p_reg   <= product[VALUE_W-1:0];
            ovf_reg <= |product[PROD_W-1:VALUE_W];
            cnt_reg <= cnt_reg + 6'd1;
        end
        if (cmd.compare) begin
            if (status.match) begin
                mask_reg[slot] <= 1'b1;
            end
            else if (!ovf_reg && (p_reg < n_reg)) begin
                lo_reg <= mid_reg + 16'd1;
            end
            else begin
                hi_reg <= mid_reg - 16'd1;
            end
        end
    end

    // an overflowed power is above any 31-bit input, so it just steers the search down
    always_comb begin
        status.sqrt_busy   = (bit_reg != '0);
        status.exp_none    = (top_reg < MIN_EXPONENT);
        status.search_over = (lo_reg > hi_reg);
        status.power_done  = ovf_reg || (cnt_reg == k_reg);
        status.match       = !ovf_reg && (p_reg == n_reg);
        status.exp_last    = (k_reg == top_reg);
    end

    assign exponent_mask = mask_reg;

endmodule

@@ sv/ppem_ctrl.sv @@
module ppem_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ppem_pkg::ppem_status_t status,
    output ppem_pkg::ppem_cmd_t    cmd,
    output logic                   busy,
    output logic                   done
);
    import ppem_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQRT,
        S_PROBE,
        S_POWER
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd.load   = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (status.sqrt_busy) begin
                    cmd.sqrt_step = 1'b1;
                end
                else if (status.exp_none) begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else begin
                    cmd.search_init = 1'b1;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE: begin
                if (status.search_over) begin
                    if (status.exp_last) begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else begin
                        cmd.exp_next    = 1'b1;
                        cmd.search_init = 1'b1;
                    end
                end
                else begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_POWER;
                end
            end
            S_POWER: begin
                if (!status.power_done) begin
                    cmd.mul_step = 1'b1;
                end
                else begin
                    cmd.compare = 1'b1;
                    state_next  = S_PROBE;
                    // a hit ends the search for this exponent
                    if (status.match) begin
                        if (status.exp_last) begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else begin
                            cmd.exp_next    = 1'b1;
                            cmd.search_init = 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

@@ sv/perfect_power_exponent_mask_core.sv @@
// Channel   | Ports                       | Transaction
// ----------+-----------------------------+------------------------------------------
// input     | start, busy, value          | taken at a clock edge with start & !busy
// result    | done, exponent_mask         | done high for one cycle, always taken
// config    | cfg_we, cfg_wdata           | max_exponent written when cfg_we is high
//
// One item at a time. A square root first, then per exponent k a binary search
// of up to 16 probes; each probe loads mid, does up to k-1 multiplications on the
// one shared 31x16 multiplier (fewer once the power passes 2^31-1) and compares.
// Reset clears the controller and sets max_exponent to 33. The receiver cannot
// stall: done is registered and rises in the cycle after the final decision.
module perfect_power_exponent_mask_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ppem_pkg::VALUE_W-1:0]   value,
    input  logic                           cfg_we,
    input  logic [ppem_pkg::EXP_W-1:0]     cfg_wdata,
    output logic                           done,
    output logic [ppem_pkg::MASK_W-1:0]    exponent_mask
);
    import ppem_pkg::*;

    ppem_cmd_t    cmd;
    ppem_status_t status;

    ppem_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ppem_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .value         (value),
        .cmd           (cmd),
        .status        (status),
        .exponent_mask (exponent_mask)
    );

endmodule
